// ----- hw/rtl/smacp_pkg.sv -----
package smacp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h40;
    localparam logic [7:0] CMD_RD16  = 8'h41;
    localparam logic [7:0] CMD_WR16  = 8'h42;
    localparam logic [7:0] CMD_RD32  = 8'h43;
    localparam logic [7:0] CMD_WR32  = 8'h44;

    localparam logic [2:0] LAST_ADDR_BYTE  = 3'd3;
    localparam logic [2:0] LAST_WR16_BYTE  = 3'd5;
    localparam logic [2:0] LAST_WR32_BYTE  = 3'd7;
    localparam logic [1:0] LAST_RD16_INDEX = 2'd1;
    localparam logic [1:0] LAST_RD32_INDEX = 2'd3;
    localparam logic [1:0] LAST_WR_INDEX   = 2'd3;

endpackage

// ----- hw/rtl/serial_memory_access_command_parser.sv -----
// Command bytes are taken one per cycle, and the input waits while a command
// executes; the request that ends a command starts its execution in the next cycle.
// A write stores four data bytes in memory and then sends its acknowledge; a read
// sends the acknowledge, then its read bytes (two for 'A', four for 'C').
// Reset clears the parser and then zeroes the memory, one byte per cycle, over all
// 2^MEM_ADDR_BITS addresses; no request is accepted during that pass.
module serial_memory_access_command_parser #(
    parameter int MEM_ADDR_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
    output logic       m_axis_tlast
);
    import smacp_pkg::*;

    localparam int MemDepth = 1 << MEM_ADDR_BITS;

    typedef enum logic [2:0] {
        P_IDLE,
        P_CMD,
        P_RD16,
        P_WR16,
        P_RD32,
        P_WR32
    } t_phase;

    typedef enum logic [2:0] {
        E_CLR,
        E_IDLE,
        E_WR,
        E_ACK,
        E_RD_ISSUE,
        E_RD_WAIT
    } t_exec;

    t_phase                     r_ph;
    t_exec                      r_ex;
    logic [2:0]                 r_cnt;
    logic [31:0]                r_addr;
    logic [31:0]                r_data;
    logic [1:0]                 r_idx;
    logic                       r_is_rd;
    logic                       r_is32;
    logic [MEM_ADDR_BITS-1:0]   r_clr_addr;
    logic                       r_out_valid;
    logic [7:0]                 r_out_data;
    logic                       r_out_last;
    logic [7:0]                 r_mem_q;
    logic [7:0]                 mem [MemDepth];

    logic                       acc;
    logic                       slot_free;
    logic [7:0]                 b;
    logic [MEM_ADDR_BITS-1:0]   acc_addr;
    logic                       mem_we;
    logic                       mem_re;
    logic [MEM_ADDR_BITS-1:0]   mem_waddr;
    logic [7:0]                 mem_wdata;
    logic                       rd_last;

    assign s_axis_tready = (r_ex == E_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign acc_addr      = r_addr[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(r_idx);
    assign rd_last       = (r_idx == (r_is32 ? LAST_RD32_INDEX : LAST_RD16_INDEX));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        mem_we    = (r_ex == E_CLR) || (r_ex == E_WR);
        mem_re    = (r_ex == E_RD_ISSUE);
        mem_waddr = (r_ex == E_CLR) ? r_clr_addr : acc_addr;
        mem_wdata = (r_ex == E_CLR) ? 8'h00 : r_data[{r_idx, 3'b000} +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= P_IDLE;
            r_ex        <= E_CLR;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_is_rd     <= 1'b0;
            r_is32      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (acc) begin
                unique case (r_ph)
                    P_IDLE: begin
                        if (b == SYNC_BYTE) begin
                            r_ph <= P_CMD;
                        end
                    end
                    P_CMD: begin
                        r_cnt  <= '0;
                        r_addr <= '0;
                        r_data <= '0;
                        priority if (b == CMD_RD16) begin
                            r_ph <= P_RD16;
                        end else if (b == CMD_WR16) begin
                            r_ph <= P_WR16;
                        end else if (b == CMD_RD32) begin
                            r_ph <= P_RD32;
                        end else if (b == CMD_WR32) begin
                            r_ph <= P_WR32;
                        end else begin
                            r_ph <= P_IDLE;
                        end
                    end
                    P_RD16, P_RD32, P_WR16, P_WR32: begin
                        if (!r_cnt[2]) begin
                            r_addr[{r_cnt[1:0], 3'b000} +: 8] <= b;
                        end else begin
                            r_data[{r_cnt[1:0], 3'b000} +: 8] <= b;
                        end
                        r_cnt <= r_cnt + 3'd1;
                        r_idx <= '0;
                        if (((r_ph == P_RD16 || r_ph == P_RD32) && r_cnt == LAST_ADDR_BYTE)
                            || (r_ph == P_WR16 && r_cnt == LAST_WR16_BYTE)
                            || (r_ph == P_WR32 && r_cnt == LAST_WR32_BYTE)) begin
                            r_ph    <= P_IDLE;
                            r_cnt   <= '0;
                            r_is_rd <= (r_ph == P_RD16) || (r_ph == P_RD32);
                            r_is32  <= (r_ph == P_RD32);
                            r_ex    <= ((r_ph == P_RD16) || (r_ph == P_RD32)) ? E_ACK : E_WR;
                        end
                    end
                    default: begin
                        r_ph <= P_IDLE;
                    end
                endcase
            end

            unique case (r_ex)
                E_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_ex <= E_IDLE;
                    end
                end
                E_IDLE: begin
                end
                E_WR: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == LAST_WR_INDEX) begin
                        r_ex <= E_ACK;
                    end
                end
                E_ACK: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= SYNC_BYTE;
                        r_out_last  <= !r_is_rd;
                        r_idx       <= '0;
                        r_ex        <= r_is_rd ? E_RD_ISSUE : E_IDLE;
                    end
                end
                E_RD_ISSUE: begin
                    r_ex <= E_RD_WAIT;
                end
                E_RD_WAIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_mem_q;
                        r_out_last  <= rd_last;
                        r_idx       <= r_idx + 2'd1;
                        r_ex        <= rd_last ? E_IDLE : E_RD_ISSUE;
                    end
                end
                default: begin
                    r_ex <= E_IDLE;
                end
            endcase
        end
    end

    a_rw_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> !mem_we)
        else $error("memory read and write issued in the same cycle");

    a_parser_idle_in_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex != E_IDLE && r_ex != E_CLR) |-> (r_ph == P_IDLE))
        else $error("parser left idle while a command is being executed");

    a_ack_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex == E_WR && r_idx == LAST_WR_INDEX) |=> (r_ex == E_ACK && r_idx == 2'd0))
        else $error("acknowledge entered with a stale byte index");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending reply byte overwritten");

endmodule
